>>> rtl/core/dmx_pkg.sv
// Shared types and constants of the DMX512 frame transmitter.
// Used by dmx_apb_regs and dmx512_frame_transmitter; depends on nothing.
`default_nettype none

package dmx_pkg;

	localparam int unsigned MAX_SLOTS  = 512;
	localparam int unsigned SLOT_AW    = $clog2(MAX_SLOTS + 1);
	localparam int unsigned FRAME_BITS = 11;

	localparam int unsigned CFG_AW  = 5;
	localparam int unsigned CFG_DW  = 32;
	localparam int unsigned IN_DW   = 24;
	localparam int unsigned OUT_DW  = 8;

	localparam logic [2:0] REG_TX_ENABLE   = 3'd0;
	localparam logic [2:0] REG_SLOT_COUNT  = 3'd1;
	localparam logic [2:0] REG_BREAK_TICKS = 3'd2;
	localparam logic [2:0] REG_MAB_TICKS   = 3'd3;
	localparam logic [2:0] REG_BIT_TICKS   = 3'd4;

	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	localparam logic [9:0]  RST_SLOT_COUNT  = 10'd512;
	localparam logic [15:0] RST_BREAK_TICKS = 16'd7040;
	localparam logic [15:0] RST_MAB_TICKS   = 16'd480;
	localparam logic [11:0] RST_BIT_TICKS   = 12'd160;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_BREAK = 2'd1,
		PH_MAB   = 2'd2,
		PH_SLOTS = 2'd3
	} phase_t;

	typedef struct packed {
		logic        tx_enable;
		logic [9:0]  slot_count;
		logic [15:0] break_ticks;
		logic [15:0] mab_ticks;
		logic [11:0] bit_ticks;
	} cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/dmx_apb_regs.sv
// APB configuration register file of the DMX512 frame transmitter.
// Depends on dmx_pkg for the register map and the cfg_t bundle.
`default_nettype none

module dmx_apb_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [dmx_pkg::CFG_AW-1:0]   paddr,
	input  wire logic [dmx_pkg::CFG_DW-1:0]   pwdata,
	output logic      [dmx_pkg::CFG_DW-1:0]   prdata,
	output logic                              pready,
	output dmx_pkg::cfg_t                     cfg
);
	import dmx_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[CFG_AW-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tx_enable   <= 1'b0;
			cfg_q.slot_count  <= RST_SLOT_COUNT;
			cfg_q.break_ticks <= RST_BREAK_TICKS;
			cfg_q.mab_ticks   <= RST_MAB_TICKS;
			cfg_q.bit_ticks   <= RST_BIT_TICKS;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_TX_ENABLE:   cfg_q.tx_enable   <= pwdata[0];
				REG_SLOT_COUNT:  cfg_q.slot_count  <= pwdata[9:0];
				REG_BREAK_TICKS: cfg_q.break_ticks <= pwdata[15:0];
				REG_MAB_TICKS:   cfg_q.mab_ticks   <= pwdata[15:0];
				REG_BIT_TICKS:   cfg_q.bit_ticks   <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_TX_ENABLE:   prdata = {{(CFG_DW-1){1'b0}}, cfg_q.tx_enable};
			REG_SLOT_COUNT:  prdata = {{(CFG_DW-10){1'b0}}, cfg_q.slot_count};
			REG_BREAK_TICKS: prdata = {{(CFG_DW-16){1'b0}}, cfg_q.break_ticks};
			REG_MAB_TICKS:   prdata = {{(CFG_DW-16){1'b0}}, cfg_q.mab_ticks};
			REG_BIT_TICKS:   prdata = {{(CFG_DW-12){1'b0}}, cfg_q.bit_ticks};
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/dmx512_frame_transmitter.sv
// Top level of the DMX512 frame transmitter: slot store, frame sequencer, result buffer.
// Depends on dmx_pkg and dmx_apb_regs.
//
// Each accepted request is either one clock tick or a write of one slot byte, and each
// yields one result with the line level and frame phase after it. One request is taken
// every cycle while s_tready is high; the slot store is a single-port synchronous memory,
// and the byte of a slot that starts is read into rdata_q at the tick that loads it and
// passes from there into the shift register. A two-entry result buffer lets requests
// flow while a result waits. After reset the store is swept to zero while s_tready stays low.
`default_nettype none

module dmx512_frame_transmitter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [dmx_pkg::IN_DW-1:0]     s_tdata,  // slot_index[9:0], slot_value[17:10]
	input  wire logic                          s_tuser,  // req_type
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [dmx_pkg::OUT_DW-1:0]    m_tdata,  // tx_line, tx_active, frame_phase[3:2]
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [dmx_pkg::CFG_AW-1:0]    paddr,
	input  wire logic [dmx_pkg::CFG_DW-1:0]    pwdata,
	output logic      [dmx_pkg::CFG_DW-1:0]    prdata,
	output logic                               pready
);
	import dmx_pkg::*;

	cfg_t cfg;

	dmx_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [7:0] slot_mem [MAX_SLOTS+1];
	logic [7:0] rdata_q;

	logic               clr_busy_q;
	logic [SLOT_AW-1:0] clr_addr_q;

	phase_t             phase_q, phase_n;
	logic [15:0]        tick_q, tick_n;
	logic [SLOT_AW-1:0] slot_q, slot_n;
	logic [3:0]         bit_q, bit_n;
	logic [7:0]         shift_q, shift_n, shift_cur;
	logic               pend_q;

	logic               load;
	logic [SLOT_AW-1:0] load_idx;
	logic [SLOT_AW-1:0] last_slot;
	logic               line_n;

	logic               acc;
	logic [SLOT_AW-1:0] wr_idx;
	logic               wr_ok;

	logic [OUT_DW-1:0]  obuf_q [2];
	logic               wptr_q, rptr_q;
	logic [1:0]         cnt_q;
	logic               pop;

	assign acc      = s_tvalid && s_tready;
	assign s_tready = !clr_busy_q && (cnt_q != 2'd2);
	assign wr_idx   = s_tdata[SLOT_AW-1:0];
	assign wr_ok    = (wr_idx <= SLOT_AW'(MAX_SLOTS));
	assign shift_cur = pend_q ? rdata_q : shift_q;
	assign last_slot = (cfg.slot_count > SLOT_AW'(MAX_SLOTS)) ? SLOT_AW'(MAX_SLOTS)
		: cfg.slot_count;

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			slot_mem[clr_addr_q] <= '0;
		end else if (acc && s_tuser == REQ_WRITE && wr_ok) begin
			slot_mem[wr_idx] <= s_tdata[SLOT_AW+7:SLOT_AW];
		end
		if (acc && load) begin
			rdata_q <= slot_mem[load_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == SLOT_AW'(MAX_SLOTS)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	always_comb begin
		phase_n  = phase_q;
		tick_n   = tick_q;
		slot_n   = slot_q;
		bit_n    = bit_q;
		shift_n  = shift_cur;
		load     = 1'b0;
		load_idx = '0;
		if (s_tuser == REQ_TICK) begin
			if (!cfg.tx_enable) begin
				phase_n = PH_IDLE;
				tick_n  = '0;
				slot_n  = '0;
				bit_n   = '0;
				shift_n = '0;
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
						phase_n = PH_BREAK;
						tick_n  = 16'd1;
					end
					PH_BREAK: begin
						if (tick_q >= cfg.break_ticks) begin
							phase_n = PH_MAB;
							tick_n  = 16'd1;
						end else begin
							tick_n = tick_q + 16'd1;
						end
					end
					PH_MAB: begin
						if (tick_q >= cfg.mab_ticks) begin
							phase_n  = PH_SLOTS;
							load     = 1'b1;
							load_idx = '0;
							slot_n   = '0;
							bit_n    = '0;
							tick_n   = 16'd1;
							shift_n  = '0;
						end else begin
							tick_n = tick_q + 16'd1;
						end
					end
					PH_SLOTS: begin
						if (tick_q < {4'd0, cfg.bit_ticks}) begin
							tick_n = tick_q + 16'd1;
						end else begin
							if (bit_q >= 4'd2 && bit_q <= 4'd8) begin
								shift_n = shift_cur >> 1;
							end
							bit_n  = bit_q + 4'd1;
							tick_n = 16'd1;
							if (bit_n >= 4'(FRAME_BITS)) begin
								if ({1'b0, slot_q} + 1'b1 > {1'b0, last_slot}) begin
									phase_n = PH_BREAK;
									slot_n  = '0;
									bit_n   = '0;
									shift_n = '0;
								end else begin
									load     = 1'b1;
									load_idx = slot_q + 1'b1;
									slot_n   = slot_q + 1'b1;
									bit_n    = '0;
									shift_n  = '0;
								end
							end
						end
					end
				endcase
			end
		end
	end

	always_comb begin
		if (phase_n == PH_BREAK) begin
			line_n = 1'b0;
		end else if (phase_n != PH_SLOTS) begin
			line_n = 1'b1;
		end else if (bit_n == 4'd0) begin
			line_n = 1'b0;
		end else if (bit_n <= 4'd8) begin
			line_n = shift_n[0];
		end else begin
			line_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			slot_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			pend_q  <= 1'b0;
		end else if (acc) begin
			phase_q <= phase_n;
			tick_q  <= tick_n;
			slot_q  <= slot_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			pend_q  <= load;
		end else if (pend_q) begin
			shift_q <= rdata_q;
			pend_q  <= 1'b0;
		end
	end

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = obuf_q[rptr_q];

	always_ff @(posedge clk) begin
		if (acc) begin
			obuf_q[wptr_q] <= {4'd0, phase_n, (phase_n == PH_SLOTS), line_n};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (acc) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, acc} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) clr_busy_q |-> !s_tready)
		else $error("Request taken during the slot store sweep.");

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("Result buffer overflow.");

	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (phase_q == PH_SLOTS && bit_q == 4'd0))
		else $error("Slot byte pending outside the start bit.");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1] == (m_tdata[3:2] == PH_SLOTS)))
		else $error("Active flag disagrees with frame phase.");

endmodule

`default_nettype wire

>>> bench/tb_dmx512_frame_transmitter.sv
// Self-checking testbench for the DMX512 frame transmitter: drives ticks and slot writes,
// predicts the line level and frame phase of every request and checks each result.
// Depends on dmx_pkg and the dmx512_frame_transmitter RTL.
`timescale 1ns / 100ps

module tb_dmx512_frame_transmitter;

	import dmx_pkg::*;

	typedef struct packed {
		logic   line;
		logic   active;
		phase_t phase;
	} line_state_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_DW-1:0]    s_tdata = '0;   // slot_index[9:0], slot_value[17:10]
	logic                s_tuser = 1'b0; // req_type
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_DW-1:0]   m_tdata;        // tx_line, tx_active, frame_phase[3:2]
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [CFG_AW-1:0]   paddr = '0;
	logic [CFG_DW-1:0]   pwdata = '0;
	logic [CFG_DW-1:0]   prdata;
	logic                pready;

	dmx512_frame_transmitter dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	cfg_t        line_cfg;
	logic [7:0]  slot_mem [0:MAX_SLOTS];
	phase_t      ph;
	logic [15:0] tick_cnt;
	logic [9:0]  slot_num;
	logic [3:0]  bit_num;
	logic [7:0]  shift_byte;

	line_state_t pending_line_states [$];
	int          fail_cnt = 0;
	int          src_idle_pct = 0;
	int          snk_idle_pct = 0;
	int          hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic note_failure(input string msg);
		fail_cnt++;
		if (fail_cnt <= 10) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	function automatic void load_slot(input int unsigned idx);
		slot_num = idx[9:0];
		bit_num = 4'd0;
		shift_byte = slot_mem[idx];
		tick_cnt = 16'd1;
	endfunction

	function automatic void advance_tick();
		int unsigned last;
		last = (line_cfg.slot_count > MAX_SLOTS) ? MAX_SLOTS : line_cfg.slot_count;
		if (!line_cfg.tx_enable) begin
			ph = PH_IDLE;
			tick_cnt = '0;
			slot_num = '0;
			bit_num = '0;
			shift_byte = '0;
			return;
		end
		case (ph)
			PH_IDLE: begin
				ph = PH_BREAK;
				tick_cnt = 16'd1;
			end
			PH_BREAK: begin
				if (tick_cnt >= line_cfg.break_ticks) begin
					ph = PH_MAB;
					tick_cnt = 16'd1;
				end else begin
					tick_cnt = tick_cnt + 16'd1;
				end
			end
			PH_MAB: begin
				if (tick_cnt >= line_cfg.mab_ticks) begin
					ph = PH_SLOTS;
					load_slot(0);
				end else begin
					tick_cnt = tick_cnt + 16'd1;
				end
			end
			default: begin
				if (tick_cnt < line_cfg.bit_ticks) begin
					tick_cnt = tick_cnt + 16'd1;
				end else begin
					if (bit_num >= 2 && bit_num <= 8) begin
						shift_byte = shift_byte >> 1;
					end
					bit_num = bit_num + 4'd1;
					tick_cnt = 16'd1;
					if (bit_num >= FRAME_BITS) begin
						if (slot_num + 1 > last) begin
							ph = PH_BREAK;
							slot_num = '0;
							bit_num = '0;
							shift_byte = '0;
						end else begin
							load_slot(slot_num + 1);
						end
					end
				end
			end
		endcase
	endfunction

	function automatic logic line_level();
		if (ph == PH_BREAK) return 1'b0;
		if (ph != PH_SLOTS) return 1'b1;
		if (bit_num == 0) return 1'b0;
		if (bit_num <= 8) return shift_byte[0];
		return 1'b1;
	endfunction

	function automatic line_state_t predict_line_state(input logic rtype, input logic [9:0] idx,
			input logic [7:0] val);
		line_state_t s;
		if (rtype == REQ_WRITE) begin
			if (idx <= MAX_SLOTS) slot_mem[idx] = val;
		end else begin
			advance_tick();
		end
		s.line = line_level();
		s.active = (ph == PH_SLOTS);
		s.phase = ph;
		return s;
	endfunction

	function automatic void reset_line_model();
		foreach (slot_mem[i]) slot_mem[i] = 8'h00;
		ph = PH_IDLE;
		tick_cnt = '0;
		slot_num = '0;
		bit_num = '0;
		shift_byte = '0;
		line_cfg.tx_enable = 1'b0;
		line_cfg.slot_count = RST_SLOT_COUNT;
		line_cfg.break_ticks = RST_BREAK_TICKS;
		line_cfg.mab_ticks = RST_MAB_TICKS;
		line_cfg.bit_ticks = RST_BIT_TICKS;
	endfunction

	// One request per call; tvalid stays high afterwards so back-to-back requests flow.
	task automatic send_request(input logic rtype, input logic [9:0] idx, input logic [7:0] val);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= rtype;
		s_tdata <= {6'd0, val, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_line_states.push_back(predict_line_state(rtype, idx, val));
	endtask

	task automatic send_tick();
		send_request(REQ_TICK, 10'($urandom_range(1023, 0)), 8'($urandom_range(255, 0)));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_line_states.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] reg_idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (reg_idx)
			REG_TX_ENABLE:   line_cfg.tx_enable = value[0];
			REG_SLOT_COUNT:  line_cfg.slot_count = value[9:0];
			REG_BREAK_TICKS: line_cfg.break_ticks = value[15:0];
			REG_MAB_TICKS:   line_cfg.mab_ticks = value[15:0];
			REG_BIT_TICKS:   line_cfg.bit_ticks = value[11:0];
			default: ;
		endcase
	endtask

	task automatic set_timing(input logic [31:0] slots, input logic [31:0] brk,
			input logic [31:0] mab, input logic [31:0] bit_len, input logic enable);
		drain_results();
		write_reg(REG_SLOT_COUNT, slots);
		write_reg(REG_BREAK_TICKS, brk);
		write_reg(REG_MAB_TICKS, mab);
		write_reg(REG_BIT_TICKS, bit_len);
		write_reg(REG_TX_ENABLE, {31'd0, enable});
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		line_state_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_line_states.size() == 0) begin
				note_failure($sformatf("result with nothing expected: tdata=%h", m_tdata));
			end else begin
				want = pending_line_states.pop_front();
				if (m_tdata[0] !== want.line || m_tdata[1] !== want.active ||
						m_tdata[3:2] !== want.phase) begin
					note_failure($sformatf(
						"expected line=%0b active=%0b phase=%0d, got line=%0b active=%0b phase=%0d",
						want.line, want.active, want.phase, m_tdata[0], m_tdata[1], m_tdata[3:2]));
				end
			end
		end
	end

	task automatic test_idle_and_writes();
		send_tick();
		send_request(REQ_WRITE, 10'd0, 8'hA5);
		send_request(REQ_WRITE, 10'd512, 8'hFF);
		send_request(REQ_WRITE, 10'd513, 8'h5A);
		send_request(REQ_WRITE, 10'd1023, 8'hFF);
		send_request(REQ_WRITE, 10'd1, 8'h00);
		send_request(REQ_WRITE, 10'd2, 8'h81);
		send_request(REQ_TICK, 10'h3FF, 8'hFF);
		send_request(REQ_TICK, 10'h000, 8'h00);
	endtask

	// Zero durations act as one tick; a zero slot count sends only the start code.
	task automatic test_short_frame();
		set_timing(0, 0, 0, 0, 1'b1);
		repeat (18) send_tick();
		drain_results();
		write_reg(REG_TX_ENABLE, 32'd0);
		repeat (2) send_tick();
	endtask

	// A slot rewritten just after it was loaded must still go out with its old byte.
	task automatic test_write_during_send();
		set_timing(2, 1, 1, 1, 1'b1);
		repeat (3) send_tick();
		send_request(REQ_WRITE, 10'd0, 8'h3C);
		repeat (11) send_tick();
		send_request(REQ_WRITE, 10'd1, 8'hC3);
		send_request(REQ_WRITE, 10'd2, 8'h0F);
		repeat (40) send_tick();
	endtask

	task automatic test_count_change_mid_frame();
		set_timing(4, 2, 1, 1, 1'b1);
		repeat (26) send_tick();
		drain_results();
		write_reg(REG_SLOT_COUNT, 32'd1);
		repeat (20) send_tick();
	endtask

	// A count above the store size must keep the frame running through its slots.
	task automatic test_slot_count_limit();
		int saved_src;
		int saved_snk;
		saved_src = src_idle_pct;
		saved_snk = snk_idle_pct;
		set_timing(1023, 1, 1, 1, 1'b1);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		repeat (5 * FRAME_BITS + 4) send_tick();
		drain_results();
		src_idle_pct = saved_src;
		snk_idle_pct = saved_snk;
	endtask

	task automatic test_long_durations();
		set_timing(512, 65535, 65535, 4095, 1'b1);
		repeat (6) send_tick();
		drain_results();
		write_reg(REG_BREAK_TICKS, 32'd1);
		repeat (4) send_tick();
	endtask

	task automatic test_output_backpressure();
		int saved_src;
		saved_src = src_idle_pct;
		set_timing(2, 1, 2, 1, 1'b1);
		src_idle_pct = 0;
		hold_left = 400;
		repeat (80) send_tick();
		drain_results();
		src_idle_pct = saved_src;
	endtask

	function automatic logic [31:0] pick_duration(input int unsigned top, input int unsigned short_hi);
		int unsigned p;
		p = $urandom_range(9, 0);
		if (p == 0) return top;
		if (p == 1) return $urandom_range(short_hi * 10, short_hi + 1);
		return $urandom_range(short_hi, 0);
	endfunction

	task automatic pick_random_config();
		int unsigned p;
		drain_results();
		if ($urandom_range(9, 0) < 6) begin
			p = $urandom_range(9, 0);
			if (p < 7) write_reg(REG_SLOT_COUNT, $urandom_range(4, 0));
			else if (p == 7) write_reg(REG_SLOT_COUNT, MAX_SLOTS);
			else if (p == 8) write_reg(REG_SLOT_COUNT, 32'd1023);
			else write_reg(REG_SLOT_COUNT, $urandom_range(700, 5));
		end
		if ($urandom_range(9, 0) < 6) write_reg(REG_BREAK_TICKS, pick_duration(65535, 3));
		if ($urandom_range(9, 0) < 6) write_reg(REG_MAB_TICKS, pick_duration(65535, 3));
		if ($urandom_range(9, 0) < 6) write_reg(REG_BIT_TICKS, pick_duration(4095, 2));
		write_reg(REG_TX_ENABLE, {31'd0, ($urandom_range(7, 0) != 0)});
	endtask

	task automatic send_random_request();
		int unsigned p;
		logic [9:0] idx;
		p = $urandom_range(99, 0);
		if (p < 18) idx = 10'($urandom_range(7, 0));
		else if (p < 22) idx = 10'($urandom_range(MAX_SLOTS, 0));
		else idx = 10'($urandom_range(1023, 0));
		send_request((p < 25) ? REQ_WRITE : REQ_TICK, idx, 8'($urandom_range(255, 0)));
	endtask

	task automatic test_random_traffic(input int n_items, input int src_pct, input int snk_pct);
		int sent;
		int burst;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		sent = 0;
		while (sent < n_items) begin
			pick_random_config();
			burst = $urandom_range(110, 30);
			repeat (burst) send_random_request();
			sent += burst;
		end
		drain_results();
	endtask

	initial begin
		reset_line_model();
		src_idle_pct = 32;
		snk_idle_pct = 80;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_idle_and_writes();
		test_short_frame();
		test_write_during_send();
		test_count_change_mid_frame();
		test_slot_count_limit();
		test_long_durations();
		test_output_backpressure();
		test_random_traffic(420, 32, 80);
		test_random_traffic(420, 80, 32);
		test_random_traffic(420, 0, 0);

		drain_results();
		repeat (10) @(posedge clk);
		if (pending_line_states.size() != 0) begin
			note_failure($sformatf("%0d results never arrived", pending_line_states.size()));
		end
		if (fail_cnt == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
